/* src/bresenham_line_rasterizer_unit_assert.svh */
// ----------------------------------------------------------------------------
// bresenham line rasterizer assertion macros
// shorthand for clocked assertions, reset held low disables them
// ----------------------------------------------------------------------------
`ifndef BRESENHAM_LINE_RASTERIZER_UNIT_ASSERT_SVH
`define BRESENHAM_LINE_RASTERIZER_UNIT_ASSERT_SVH

// same-cycle implication
`define BRL_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BRL_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/brl_pkg.sv */
// ----------------------------------------------------------------------------
// brl_pkg
// shared types and constants of the bresenham line rasterizer
// ----------------------------------------------------------------------------
package brl_pkg;

  localparam int COORD_BITS     = 12;
  localparam int COLOUR_BITS    = 24;
  localparam int ERR_BITS       = COORD_BITS + 3;
  localparam int IN_FIELD_BITS  = 4 * COORD_BITS + COLOUR_BITS;
  localparam int IN_DATA_BITS   = ((IN_FIELD_BITS + 7) / 8) * 8;
  localparam int OUT_FIELD_BITS = 2 * COORD_BITS + COLOUR_BITS;
  localparam int OUT_DATA_BITS  = ((OUT_FIELD_BITS + 7) / 8) * 8;
  localparam int QUEUE_DEPTH    = 2;
  localparam int QPTR_BITS      = $clog2(QUEUE_DEPTH);

  typedef enum logic {
    MODE_START = 1'b0,
    MODE_NEXT  = 1'b1
  } mode_t;

  typedef logic [COORD_BITS-1:0]       coord_t;
  typedef logic [COLOUR_BITS-1:0]      colour_t;
  typedef logic signed [ERR_BITS-1:0]  err_t;

  // classified command handed from front to back
  typedef struct packed {
    logic    is_start;
    logic    x_major;
    coord_t  maj_pos;
    coord_t  maj_end;
    coord_t  min_pos;
    logic    step_down;
    err_t    err_init;
    err_t    err_diag;
    err_t    err_axial;
    colour_t colour;
  } cmd_t;

  typedef struct packed {
    coord_t  x;
    coord_t  y;
    colour_t colour;
    logic    valid;
    logic    last;
  } pix_t;

  function automatic coord_t abs_diff(coord_t a, coord_t b);
    return (a >= b) ? coord_t'(a - b) : coord_t'(b - a);
  endfunction

endpackage

/* src/brl_front.sv */
// ----------------------------------------------------------------------------
// brl_front
// accepts items, sorts endpoints along the major axis and sets up the error
// ----------------------------------------------------------------------------
module brl_front (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [brl_pkg::IN_DATA_BITS-1:0]     in_tdata,
  input  logic                                 in_tuser,
  output logic                                 cmd_valid,
  input  logic                                 cmd_ready,
  output brl_pkg::cmd_t                        cmd
);
  import brl_pkg::*;

  localparam int SY_LO = COORD_BITS;
  localparam int EX_LO = 2 * COORD_BITS;
  localparam int EY_LO = 3 * COORD_BITS;
  localparam int CL_LO = 4 * COORD_BITS;

  logic    cv_r, cv_nxt;
  cmd_t    cmd_r, cmd_nxt;
  logic    accept;

  coord_t  sx, sy, ex, ey;
  coord_t  adx, ady;
  coord_t  ma0, ma1, mi0, mi1;
  coord_t  maj_s, maj_e, min_s, min_e;
  coord_t  maj_d, min_d;
  logic    xm, swap;
  err_t    two_mi, two_ma;

  assign sx = in_tdata[SY_LO-1:0];
  assign sy = in_tdata[EX_LO-1:SY_LO];
  assign ex = in_tdata[EY_LO-1:EX_LO];
  assign ey = in_tdata[CL_LO-1:EY_LO];

  assign in_tready = !cv_r || cmd_ready;
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    adx    = abs_diff(ex, sx);
    ady    = abs_diff(ey, sy);
    xm     = (adx >= ady);
    ma0    = xm ? sx : sy;
    ma1    = xm ? ex : ey;
    mi0    = xm ? sy : sx;
    mi1    = xm ? ey : ex;
    maj_d  = xm ? adx : ady;
    min_d  = xm ? ady : adx;
    // walk so the major coordinate rises
    swap   = (ma0 > ma1);
    maj_s  = swap ? ma1 : ma0;
    maj_e  = swap ? ma0 : ma1;
    min_s  = swap ? mi1 : mi0;
    min_e  = swap ? mi0 : mi1;
    two_mi = err_t'({2'b00, min_d, 1'b0});
    two_ma = err_t'({2'b00, maj_d, 1'b0});

    cmd_nxt.is_start  = (mode_t'(in_tuser) == MODE_START);
    cmd_nxt.x_major   = xm;
    cmd_nxt.maj_pos   = maj_s;
    cmd_nxt.maj_end   = maj_e;
    cmd_nxt.min_pos   = min_s;
    cmd_nxt.step_down = (min_e < min_s);
    cmd_nxt.err_init  = two_mi - err_t'({3'b000, maj_d});
    cmd_nxt.err_diag  = two_mi - two_ma;
    cmd_nxt.err_axial = two_mi;
    cmd_nxt.colour    = in_tdata[CL_LO+COLOUR_BITS-1:CL_LO];

    if (accept) begin
      cv_nxt = 1'b1;
    end else if (cmd_ready) begin
      cv_nxt = 1'b0;
    end else begin
      cv_nxt = cv_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cv_r <= 1'b0;
    end else begin
      cv_r <= cv_nxt;
    end
    if (accept) begin
      cmd_r <= cmd_nxt;
    end
  end

  assign cmd_valid = cv_r;
  assign cmd       = cmd_r;

endmodule

/* src/brl_queue.sv */
// ----------------------------------------------------------------------------
// brl_queue
// short register fifo of classified commands between front and back
// ----------------------------------------------------------------------------
module brl_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_valid,
  output logic          wr_ready,
  input  brl_pkg::cmd_t wr_cmd,
  output logic          rd_valid,
  input  logic          rd_ready,
  output brl_pkg::cmd_t rd_cmd
);
  import brl_pkg::*;

  cmd_t                 slot_r [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wp_r, wp_nxt;
  logic [QPTR_BITS-1:0] rp_r, rp_nxt;
  logic [QPTR_BITS:0]   cnt_r, cnt_nxt;
  logic                 push, pop;

  assign wr_ready = (cnt_r != (QPTR_BITS+1)'(QUEUE_DEPTH));
  assign rd_valid = (cnt_r != '0);
  assign rd_cmd   = slot_r[rp_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_comb begin
    wp_nxt  = push ? QPTR_BITS'(wp_r + 1'b1) : wp_r;
    rp_nxt  = pop  ? QPTR_BITS'(rp_r + 1'b1) : rp_r;
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) begin
      slot_r[wp_r] <= wr_cmd;
    end
  end

endmodule

/* src/brl_back.sv */
// ----------------------------------------------------------------------------
// brl_back
// line stepping state and registered pixel output, one command per cycle while the output is not stalled
// ----------------------------------------------------------------------------
module brl_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cmd_valid,
  output logic          cmd_ready,
  input  brl_pkg::cmd_t cmd,
  output logic          pix_valid,
  input  logic          pix_ready,
  output brl_pkg::pix_t pix
);
  import brl_pkg::*;

  logic    active_r, active_nxt;
  logic    x_major_r, step_down_r;
  coord_t  maj_pos_r, maj_end_r, min_pos_r;
  err_t    err_r, err_diag_r, err_axial_r;
  colour_t colour_r;

  logic    ov_r, ov_nxt;
  pix_t    pix_r, pix_nxt;

  logic    pop, go, last, err_pos;
  logic    cur_xm, cur_down;
  coord_t  cur_maj, cur_end, cur_min, min_nxt;
  err_t    cur_err, cur_diag, cur_axial, err_nxt;
  colour_t cur_colour;

  assign cmd_ready = !ov_r || pix_ready;
  assign pop       = cmd_valid && cmd_ready;

  always_comb begin
    // a start command takes over, even in the middle of a line
    cur_xm     = cmd.is_start ? cmd.x_major   : x_major_r;
    cur_down   = cmd.is_start ? cmd.step_down : step_down_r;
    cur_maj    = cmd.is_start ? cmd.maj_pos   : maj_pos_r;
    cur_end    = cmd.is_start ? cmd.maj_end   : maj_end_r;
    cur_min    = cmd.is_start ? cmd.min_pos   : min_pos_r;
    cur_err    = cmd.is_start ? cmd.err_init  : err_r;
    cur_diag   = cmd.is_start ? cmd.err_diag  : err_diag_r;
    cur_axial  = cmd.is_start ? cmd.err_axial : err_axial_r;
    cur_colour = cmd.is_start ? cmd.colour    : colour_r;
    go         = cmd.is_start || active_r;
    last       = (cur_maj == cur_end);

    err_pos = !cur_err[ERR_BITS-1] && (cur_err != '0);
    if (err_pos) begin
      min_nxt = cur_down ? coord_t'(cur_min - 1'b1) : coord_t'(cur_min + 1'b1);
      err_nxt = cur_err + cur_diag;
    end else begin
      min_nxt = cur_min;
      err_nxt = cur_err + cur_axial;
    end

    pix_nxt.x      = go ? (cur_xm ? cur_maj : cur_min) : '0;
    pix_nxt.y      = go ? (cur_xm ? cur_min : cur_maj) : '0;
    pix_nxt.colour = go ? cur_colour : '0;
    pix_nxt.valid  = go;
    pix_nxt.last   = go && last;

    active_nxt = active_r;
    if (pop && go) begin
      active_nxt = !last;
    end

    if (pop) begin
      ov_nxt = 1'b1;
    end else if (pix_ready) begin
      ov_nxt = 1'b0;
    end else begin
      ov_nxt = ov_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      ov_r     <= 1'b0;
    end else begin
      active_r <= active_nxt;
      ov_r     <= ov_nxt;
    end
    if (pop && go) begin
      x_major_r   <= cur_xm;
      step_down_r <= cur_down;
      maj_pos_r   <= coord_t'(cur_maj + 1'b1);
      maj_end_r   <= cur_end;
      min_pos_r   <= min_nxt;
      err_r       <= err_nxt;
      err_diag_r  <= cur_diag;
      err_axial_r <= cur_axial;
      colour_r    <= cur_colour;
    end
    if (pop) begin
      pix_r <= pix_nxt;
    end
  end

  assign pix_valid = ov_r;
  assign pix       = pix_r;

endmodule

/* src/bresenham_line_rasterizer_unit.sv */
// ----------------------------------------------------------------------------
// bresenham_line_rasterizer_unit
// integer line rasterizer, one pixel transaction out for every item in
// ----------------------------------------------------------------------------
//  channel  dir  handshake             payload
//  in_      in   in_tvalid/in_tready   tdata endpoints+colour, tuser mode
//  out_     out  out_tvalid/out_tready tdata pixel x,y,colour, tuser valid,
//                                      tlast last pixel
//
//  one item per cycle sustained while the output is not stalled; the stepping
//  loop in brl_back closes in a single cycle (error add plus coordinate step)
//  an input transaction reaches out_tvalid through the front register, the
//  queue and the output register
//  synchronous active-low reset leaves the unit idle with nothing queued
//  a stalled output keeps its result while the 2-entry queue soaks up input
// ----------------------------------------------------------------------------
module bresenham_line_rasterizer_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // start_x, start_y, end_x, end_y, line_colour
  input  logic [brl_pkg::IN_DATA_BITS-1:0]  in_tdata,
  // mode
  input  logic                              in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // pixel_x, pixel_y, pixel_colour
  output logic [brl_pkg::OUT_DATA_BITS-1:0] out_tdata,
  // pixel_valid
  output logic                              out_tuser,
  output logic                              out_tlast
);
  import brl_pkg::*;

  logic f_valid, f_ready;
  cmd_t f_cmd;
  logic q_valid, q_ready;
  cmd_t q_cmd;
  pix_t pix;

  brl_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cmd_valid (f_valid),
    .cmd_ready (f_ready),
    .cmd       (f_cmd)
  );

  brl_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_cmd   (f_cmd),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_cmd   (q_cmd)
  );

  brl_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (q_valid),
    .cmd_ready (q_ready),
    .cmd       (q_cmd),
    .pix_valid (out_tvalid),
    .pix_ready (out_tready),
    .pix       (pix)
  );

  assign out_tdata = OUT_DATA_BITS'({pix.colour, pix.y, pix.x});
  assign out_tuser = pix.valid;
  assign out_tlast = pix.last;

endmodule

/* src/brl_checker.sv */
// ----------------------------------------------------------------------------
// brl_checker
// port-level checks of the rasterizer output channel, bound to the top level
// ----------------------------------------------------------------------------
`include "bresenham_line_rasterizer_unit_assert.svh"

module brl_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [brl_pkg::OUT_DATA_BITS-1:0] out_tdata,
  input logic                              out_tuser,
  input logic                              out_tlast
);

  // a held result must not change under backpressure
  `BRL_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast), "output changed while stalled")

  // a next item while idle carries an all-zero pixel
  `BRL_ASSERT_IMP(a_idle_zero, out_tvalid && !out_tuser, out_tdata == '0 && !out_tlast, "invalid pixel carries data")

  // only a real pixel can close a line
  `BRL_ASSERT_IMP(a_last_valid, out_tvalid && out_tlast, out_tuser, "last flag on invalid pixel")

endmodule

bind bresenham_line_rasterizer_unit brl_checker u_brl_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

/* tb/bresenham_line_rasterizer_unit_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bresenham_line_rasterizer_unit_tb
// drives start and step transactions into the rasterizer and checks every
// pixel transaction against a cycle-free line stepper kept in a scoreboard
// ----------------------------------------------------------------------------
module bresenham_line_rasterizer_unit_tb;
  import brl_pkg::*;

  localparam int WATCHDOG_LIMIT = 500;
  localparam int TOTAL_ITEMS    = 430;
  localparam int CALM_FROM      = 360;
  localparam int COORD_MAX      = (1 << COORD_BITS) - 1;

  typedef logic [IN_DATA_BITS-1:0]  in_word_t;
  typedef logic [OUT_DATA_BITS-1:0] out_word_t;

  // holds the line stepper and the pixels still owed by the block
  class pixel_scoreboard;
    bit      running;
    bit      x_major;
    bit      step_down;
    coord_t  maj_pos;
    coord_t  maj_end;
    coord_t  min_pos;
    coord_t  maj_delta;
    coord_t  min_delta;
    int      err;
    colour_t colour;
    pix_t    expected_pixels[$];
    int unsigned mismatches;

    function new();
      running    = 1'b0;
      x_major    = 1'b0;
      step_down  = 1'b0;
      maj_pos    = '0;
      maj_end    = '0;
      min_pos    = '0;
      maj_delta  = '0;
      min_delta  = '0;
      err        = 0;
      colour     = '0;
      mismatches = 0;
    endfunction

    function int unsigned outstanding();
      return expected_pixels.size();
    endfunction

    function void step_pixel();
      pix_t p;
      p.last   = (maj_pos == maj_end);
      p.x      = x_major ? maj_pos : min_pos;
      p.y      = x_major ? min_pos : maj_pos;
      p.colour = colour;
      p.valid  = 1'b1;
      expected_pixels.push_back(p);
      if (err > 0) begin
        min_pos = step_down ? coord_t'(min_pos - 1'b1) : coord_t'(min_pos + 1'b1);
        err     = err + 2 * (int'(min_delta) - int'(maj_delta));
      end else begin
        err = err + 2 * int'(min_delta);
      end
      maj_pos = coord_t'(maj_pos + 1'b1);
      running = !p.last;
    endfunction

    function void note_item(mode_t mode, in_word_t data);
      int   sx, sy, ex, ey, adx, ady, ma0, ma1, mi0, mi1, t;
      pix_t idle_pix;
      if (mode == MODE_START) begin
        sx  = int'(data[COORD_BITS-1:0]);
        sy  = int'(data[2*COORD_BITS-1:COORD_BITS]);
        ex  = int'(data[3*COORD_BITS-1:2*COORD_BITS]);
        ey  = int'(data[4*COORD_BITS-1:3*COORD_BITS]);
        adx = (ex >= sx) ? ex - sx : sx - ex;
        ady = (ey >= sy) ? ey - sy : sy - ey;
        x_major = (adx >= ady);
        if (x_major) begin
          ma0 = sx; ma1 = ex; mi0 = sy; mi1 = ey;
        end else begin
          ma0 = sy; ma1 = ey; mi0 = sx; mi1 = ex;
        end
        // walk the major axis upward
        if (ma0 > ma1) begin
          t = ma0; ma0 = ma1; ma1 = t;
          t = mi0; mi0 = mi1; mi1 = t;
        end
        maj_pos   = coord_t'(ma0);
        maj_end   = coord_t'(ma1);
        min_pos   = coord_t'(mi0);
        step_down = (mi1 < mi0);
        maj_delta = coord_t'(ma1 - ma0);
        min_delta = coord_t'((mi1 >= mi0) ? mi1 - mi0 : mi0 - mi1);
        err       = 2 * int'(min_delta) - int'(maj_delta);
        colour    = data[IN_FIELD_BITS-1:4*COORD_BITS];
        step_pixel();
      end else if (!running) begin
        idle_pix = '0;
        expected_pixels.push_back(idle_pix);
      end else begin
        step_pixel();
      end
    endfunction

    function void check_pixel(out_word_t data, logic valid, logic last);
      pix_t want;
      pix_t got;
      got.x      = data[COORD_BITS-1:0];
      got.y      = data[2*COORD_BITS-1:COORD_BITS];
      got.colour = data[OUT_FIELD_BITS-1:2*COORD_BITS];
      got.valid  = valid;
      got.last   = last;
      if (expected_pixels.size() == 0) begin
        $error("unexpected pixel transaction: x %0d y %0d", got.x, got.y);
        mismatches++;
        return;
      end
      want = expected_pixels.pop_front();
      if (got.x !== want.x) begin
        $error("pixel_x mismatch: expected %0d, actual %0d", want.x, got.x);
        mismatches++;
      end
      if (got.y !== want.y) begin
        $error("pixel_y mismatch: expected %0d, actual %0d", want.y, got.y);
        mismatches++;
      end
      if (got.colour !== want.colour) begin
        $error("pixel_colour mismatch: expected %06h, actual %06h", want.colour, got.colour);
        mismatches++;
      end
      if (got.valid !== want.valid) begin
        $error("pixel_valid mismatch: expected %0b, actual %0b", want.valid, got.valid);
        mismatches++;
      end
      if (got.last !== want.last) begin
        $error("last_pixel mismatch: expected %0b, actual %0b", want.last, got.last);
        mismatches++;
      end
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_tvalid = 1'b0;
  logic      in_tready;
  in_word_t  in_tdata = '0;
  logic      in_tuser = 1'b0;
  logic      out_tvalid;
  logic      out_tready = 1'b0;
  out_word_t out_tdata;
  logic      out_tuser;
  logic      out_tlast;

  pixel_scoreboard sb;
  bit          idling = 1'b1;
  int unsigned items_sent = 0;
  int unsigned stall_left = 0;
  int unsigned quiet_cycles = 0;

  bresenham_line_rasterizer_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always #4 clk = ~clk;

  // receiver side, stalls in bursts until the calm phase
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if (rst_n && idling && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(1, 7) - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready)
        sb.note_item(mode_t'(in_tuser), in_tdata);
      if (out_tvalid && out_tready)
        sb.check_pixel(out_tdata, out_tuser, out_tlast);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("bresenham_line_rasterizer_unit verification failed");
        $finish;
      end
    end
  end

  task automatic send_item(mode_t mode, in_word_t data);
    if (idling && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= data;
    do @(posedge clk); while (!in_tready);
    items_sent++;
    if (items_sent >= CALM_FROM)
      idling = 1'b0;
  endtask

  task automatic send_start(coord_t sx, coord_t sy, coord_t ex, coord_t ey, colour_t col);
    send_item(MODE_START, {col, ey, ex, sy, sx});
  endtask

  // payload is ignored on a step, so it carries noise
  task automatic send_next();
    logic [95:0] noise;
    noise = {$urandom, $urandom, $urandom};
    send_item(MODE_NEXT, noise[IN_DATA_BITS-1:0]);
  endtask

  task automatic draw_line(coord_t sx, coord_t sy, coord_t ex, coord_t ey, colour_t col,
                           int unsigned steps);
    send_start(sx, sy, ex, ey, col);
    repeat (steps) send_next();
  endtask

  // step past the current edge first so the last accepted transaction is already noted
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.outstanding() != 0) @(posedge clk);
  endtask

  function automatic coord_t pick_coord();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return coord_t'(COORD_MAX);
      default: return coord_t'($urandom_range(0, COORD_MAX));
    endcase
  endfunction

  // endpoint within span of base, mirrored back when it would leave the grid
  function automatic coord_t near_coord(coord_t base, int span);
    int d, v;
    d = int'($urandom_range(0, 2 * span)) - span;
    v = int'(base) + d;
    if (v < 0 || v > COORD_MAX)
      v = int'(base) - d;
    return coord_t'(v);
  endfunction

  initial begin
    coord_t      sx, sy, ex, ey;
    int          adx, ady, span;
    int unsigned steps, nsteps;
    bit          mid_drain_done;
    sb = new();
    mid_drain_done = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // step with no line running
    send_next();
    // single-point lines at both corners, then a step after the end
    draw_line(0, 0, 0, 0, 24'h000000, 1);
    draw_line(coord_t'(COORD_MAX), coord_t'(COORD_MAX), coord_t'(COORD_MAX),
              coord_t'(COORD_MAX), 24'hffffff, 0);
    draw_line(10, 5, 14, 5, 24'h123456, 4);
    draw_line(7, 20, 7, 16, 24'hedcba9, 4);
    // steep, x falling
    draw_line(100, 200, 97, 206, 24'h5a5a5a, 6);
    // full-diagonal lines aborted by a new start
    draw_line(0, 0, coord_t'(COORD_MAX), coord_t'(COORD_MAX), 24'hffffff, 1);
    draw_line(coord_t'(COORD_MAX), 0, 0, coord_t'(COORD_MAX), 24'ha5a5a5, 1);
    draw_line(2, 3, 2, 3, 24'h0f0f0f, 1);
    wait_drained();

    while (items_sent < TOTAL_ITEMS) begin
      if (!mid_drain_done && items_sent >= TOTAL_ITEMS / 2) begin
        wait_drained();
        mid_drain_done = 1'b1;
      end
      if ($urandom_range(0, 9) == 0) begin
        if ($urandom_range(0, 1) == 0)
          send_next();
        else
          send_start(pick_coord(), pick_coord(), pick_coord(), pick_coord(),
                     colour_t'($urandom));
      end else begin
        span = ($urandom_range(0, 15) == 0) ? 60 : 12;
        sx = pick_coord();
        sy = pick_coord();
        ex = near_coord(sx, span);
        ey = near_coord(sy, span);
        adx = (ex >= sx) ? int'(ex) - int'(sx) : int'(sx) - int'(ex);
        ady = (ey >= sy) ? int'(ey) - int'(sy) : int'(sy) - int'(ey);
        steps = (adx > ady) ? adx : ady;
        case ($urandom_range(0, 9))
          0:       nsteps = $urandom_range(0, steps);
          1:       nsteps = steps + $urandom_range(1, 2);
          default: nsteps = steps;
        endcase
        draw_line(sx, sy, ex, ey, colour_t'($urandom), nsteps);
      end
    end

    wait_drained();
    repeat (8) @(posedge clk);
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("bresenham_line_rasterizer_unit verification clean");
    end else begin
      $display("bresenham_line_rasterizer_unit verification failed");
    end
    $finish;
  end

endmodule
